FILE: src/ptt_pkg.sv
package ptt_pkg;

	localparam int unsigned IdW = 48;
	localparam int unsigned TimeW = 32;
	localparam int unsigned ActW = 10;
	localparam int unsigned JitterBase = 10;
	localparam int unsigned JitterMod = 31;

	typedef enum logic [2:0] {
		OP_TICK    = 3'd0,
		OP_PRESS   = 3'd1,
		OP_RELEASE = 3'd2,
		OP_CLAIM   = 3'd3,
		OP_START   = 3'd4,
		OP_AUDIO   = 3'd5,
		OP_END     = 3'd6,
		OP_NONE    = 3'd7
	} opcode_t;

	typedef enum logic [2:0] {
		ST_IDLE = 3'd0,
		ST_REQ  = 3'd1,
		ST_TALK = 3'd2,
		ST_RECV = 3'd3,
		ST_BUSY = 3'd4
	} floor_t;

	localparam logic [ActW-1:0] A_REQCUE   = 10'h001;
	localparam logic [ActW-1:0] A_CLAIM    = 10'h002;
	localparam logic [ActW-1:0] A_START    = 10'h004;
	localparam logic [ActW-1:0] A_CAPON    = 10'h008;
	localparam logic [ActW-1:0] A_END      = 10'h010;
	localparam logic [ActW-1:0] A_CAPOFF   = 10'h020;
	localparam logic [ActW-1:0] A_TIMEDOUT = 10'h040;
	localparam logic [ActW-1:0] A_TOCUE    = 10'h080;
	localparam logic [ActW-1:0] A_PLAYON   = 10'h100;
	localparam logic [ActW-1:0] A_PLAYOFF  = 10'h200;

	localparam logic [1:0] REG_ID      = 2'd0;
	localparam logic [1:0] REG_WINDOW  = 2'd1;
	localparam logic [1:0] REG_MAXTALK = 2'd2;
	localparam logic [1:0] REG_REMOTE  = 2'd3;

	// classified event handed from front to back
	typedef struct packed {
		opcode_t          op;
		logic [TimeW-1:0] now;
		logic [TimeW-1:0] sess;
		logic [TimeW-1:0] arb;
		logic [IdW-1:0]   sender;
		logic             from_self;
		logic [5:0]       jitter;
	} event_t;

	typedef struct packed {
		logic [ActW-1:0]  actions;
		logic [2:0]       talk_state;
		logic [TimeW-1:0] action_session;
		logic [TimeW-1:0] current_session;
		logic [IdW-1:0]   speaker;
		logic [TimeW-1:0] own_arbitration;
	} result_t;

	localparam int unsigned EvW = $bits(event_t);
	localparam int unsigned ResW = $bits(result_t);

endpackage

FILE: src/ptt_cfg.sv
module ptt_cfg (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [4:0]           paddr,
	input  logic [63:0]          pwdata,
	output logic [63:0]          prdata,
	output logic                 pready,
	output logic [ptt_pkg::IdW-1:0] local_id,
	output logic [15:0]          window_ms,
	output logic [23:0]          max_talk,
	output logic [15:0]          remote_to
);
	logic [1:0] idx;
	assign idx = paddr[4:3];
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			local_id  <= '0;
			window_ms <= 16'd100;
			max_talk  <= 24'd60000;
			remote_to <= 16'd500;
		end else if (psel && penable && pwrite && paddr[2:0] == 3'd0) begin
			unique case (idx)
				ptt_pkg::REG_ID:      local_id  <= pwdata[47:0];
				ptt_pkg::REG_WINDOW:  window_ms <= pwdata[15:0];
				ptt_pkg::REG_MAXTALK: max_talk  <= pwdata[23:0];
				ptt_pkg::REG_REMOTE:  remote_to <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			ptt_pkg::REG_ID:      prdata = {16'd0, local_id};
			ptt_pkg::REG_WINDOW:  prdata = {48'd0, window_ms};
			ptt_pkg::REG_MAXTALK: prdata = {40'd0, max_talk};
			default:              prdata = {48'd0, remote_to};
		endcase
	end
endmodule

FILE: src/ptt_front.sv
module ptt_front (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    s_tvalid,
	output logic                    s_tready,
	input  logic [151:0]            s_tdata,
	input  logic [ptt_pkg::IdW-1:0] local_id,
	output logic                    ev_valid,
	input  logic                    ev_ready,
	output ptt_pkg::event_t         ev
);
	ptt_pkg::event_t ev_s1;
	logic            vld_q;
	logic [31:0]     arb;
	logic [7:0]      fold1;
	logic [5:0]      fold2;
	logic [4:0]      arb_mod;

	assign arb = s_tdata[98:67];
	assign s_tready = !vld_q || ev_ready;
	assign ev_valid = vld_q;
	assign ev = ev_s1;

	// arb mod 31: 32 == 1 (mod 31), so summing 5-bit digits keeps the residue
	assign fold1 = 8'(arb[4:0]) + 8'(arb[9:5]) + 8'(arb[14:10]) + 8'(arb[19:15])
		+ 8'(arb[24:20]) + 8'(arb[29:25]) + 8'(arb[31:30]);
	assign fold2 = 6'(fold1[4:0]) + 6'(fold1[7:5]);
	assign arb_mod = (fold2 >= 6'd31) ? 5'(fold2 - 6'd31) : fold2[4:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (s_tready) begin
			vld_q <= s_tvalid;
		end
	end

	// jitter term computed here so the back end sees a short path
	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			ev_s1.op        <= ptt_pkg::opcode_t'(s_tdata[2:0]);
			ev_s1.now       <= s_tdata[34:3];
			ev_s1.sess      <= s_tdata[66:35];
			ev_s1.arb       <= arb;
			ev_s1.sender    <= s_tdata[146:99];
			ev_s1.from_self <= s_tdata[146:99] == local_id;
			ev_s1.jitter    <= 6'(ptt_pkg::JitterBase) + {1'b0, arb_mod};
		end
	end
endmodule

FILE: src/ptt_fifo.sv
module ptt_fifo #(
	parameter int unsigned W = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	output logic         in_ready,
	input  logic [W-1:0] in_data,
	output logic         out_valid,
	input  logic         out_ready,
	output logic [W-1:0] out_data
);
	// two-entry queue: full throughput with registered ready
	logic [W-1:0] mem_q [2];
	logic         wp_q, rp_q;
	logic [1:0]   cnt_q;
	logic         push, pop;

	assign in_ready  = cnt_q != 2'd2;
	assign out_valid = cnt_q != 2'd0;
	assign out_data  = mem_q[rp_q];
	assign push = in_valid && in_ready;
	assign pop  = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= !wp_q;
			if (pop) rp_q <= !rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= in_data;
	end
endmodule

FILE: src/ptt_back.sv
module ptt_back (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    ev_valid,
	output logic                    ev_ready,
	input  ptt_pkg::event_t         ev,
	input  logic [ptt_pkg::IdW-1:0] local_id,
	input  logic [15:0]             window_ms,
	input  logic [23:0]             max_talk,
	input  logic [15:0]             remote_to,
	output logic                    m_tvalid,
	input  logic                    m_tready,
	output ptt_pkg::result_t        res
);
	ptt_pkg::floor_t st_q, st_d;
	logic        held_q, held_d, cdone_q, cdone_d;
	logic [31:0] own_q, own_d, stamp_q, stamp_d, bval_q, bval_d;
	logic [47:0] bnode_q, bnode_d, hnode_q, hnode_d;
	logic [31:0] hsess_q, hsess_d, snap_q, snap_d, tstart_q, tstart_d;
	logic [31:0] cdue_q, cdue_d, rdue_q, rdue_d, seen_q, seen_d;
	logic [9:0]  act;
	logic        vld_q, fire;
	logic [31:0] nsess, d_claim, d_res, d_talk, d_seen;
	logic        listening, same;

	assign ev_ready = !vld_q || m_tready;
	assign fire = ev_valid && ev_ready;
	assign m_tvalid = vld_q;

	assign listening = st_q == ptt_pkg::ST_RECV || st_q == ptt_pkg::ST_BUSY;
	assign same = listening && ev.sess == hsess_q && ev.sender == hnode_q;
	assign d_claim = ev.now - cdue_q;
	assign d_res   = ev.now - rdue_q;
	assign d_talk  = ev.now - tstart_q;
	assign d_seen  = ev.now - seen_q;
	assign nsess = (ev.sess == '0) ? 32'd1 : ev.sess;

	always_comb begin
		st_d = st_q; held_d = held_q; cdone_d = cdone_q; own_d = own_q;
		stamp_d = stamp_q; bval_d = bval_q; bnode_d = bnode_q; hnode_d = hnode_q;
		hsess_d = hsess_q; snap_d = snap_q; tstart_d = tstart_q; cdue_d = cdue_q;
		rdue_d = rdue_q; seen_d = seen_q; act = '0;
		unique case (ev.op)
			ptt_pkg::OP_TICK: begin
				if (st_q == ptt_pkg::ST_REQ) begin
					if (!cdone_q && !d_claim[31]) begin
						cdone_d = 1'b1;
						act = act | ptt_pkg::A_CLAIM;
					end
					if (!d_res[31]) begin
						if (bnode_q == local_id && held_q) begin
							stamp_d = own_q;
							st_d = ptt_pkg::ST_TALK;
							hnode_d = local_id;
							tstart_d = ev.now;
							act = act | ptt_pkg::A_START | ptt_pkg::A_CAPON;
						end else begin
							st_d = ptt_pkg::ST_IDLE;
						end
					end
				end else if (st_q == ptt_pkg::ST_TALK && d_talk >= {8'd0, max_talk}) begin
					stamp_d = own_q;
					st_d = ptt_pkg::ST_IDLE;
					held_d = 1'b0;
					act = ptt_pkg::A_END | ptt_pkg::A_CAPOFF | ptt_pkg::A_TIMEDOUT
						| ptt_pkg::A_TOCUE;
				end else if (listening && d_seen >= {16'd0, remote_to}) begin
					st_d = ptt_pkg::ST_IDLE;
					act = ptt_pkg::A_PLAYOFF;
				end
			end
			ptt_pkg::OP_PRESS: begin
				held_d = 1'b1;
				if (st_q == ptt_pkg::ST_RECV) begin
					st_d = ptt_pkg::ST_BUSY;
				end else if (st_q == ptt_pkg::ST_IDLE) begin
					own_d = nsess; stamp_d = nsess; bval_d = ev.arb;
					bnode_d = local_id; st_d = ptt_pkg::ST_REQ; hsess_d = nsess;
					snap_d = ev.arb; hnode_d = '0;
					cdue_d = ev.now + {26'd0, ev.jitter};
					rdue_d = ev.now + {16'd0, window_ms};
					cdone_d = 1'b0;
					act = ptt_pkg::A_REQCUE;
				end
			end
			ptt_pkg::OP_RELEASE: begin
				held_d = 1'b0;
				if (st_q == ptt_pkg::ST_TALK) begin
					stamp_d = own_q;
					st_d = ptt_pkg::ST_IDLE;
					act = ptt_pkg::A_END | ptt_pkg::A_CAPOFF;
				end else if (st_q == ptt_pkg::ST_REQ) begin
					st_d = ptt_pkg::ST_IDLE;
				end else if (st_q == ptt_pkg::ST_BUSY) begin
					st_d = ptt_pkg::ST_RECV;
				end
			end
			ptt_pkg::OP_CLAIM: begin
				if (!ev.from_self && st_q == ptt_pkg::ST_REQ &&
					(ev.arb < bval_q || (ev.arb == bval_q && ev.sender < bnode_q))) begin
					bval_d = ev.arb;
					bnode_d = ev.sender;
				end
			end
			ptt_pkg::OP_START: begin
				if (ev.from_self) begin
				end else if (same) begin
					seen_d = ev.now;
				end else if (listening) begin
					if (ev.sender < hnode_q) begin
						hsess_d = ev.sess; hnode_d = ev.sender;
						tstart_d = ev.now; seen_d = ev.now;
					end
				end else if (!(st_q == ptt_pkg::ST_TALK && local_id < ev.sender)) begin
					if (st_q == ptt_pkg::ST_TALK) act = ptt_pkg::A_CAPOFF;
					act = act | ptt_pkg::A_PLAYON;
					st_d = held_q ? ptt_pkg::ST_BUSY : ptt_pkg::ST_RECV;
					hsess_d = ev.sess; hnode_d = ev.sender;
					tstart_d = ev.now; seen_d = ev.now;
				end
			end
			ptt_pkg::OP_AUDIO: begin
				if (same) seen_d = ev.now;
			end
			ptt_pkg::OP_END: begin
				if (same) begin
					st_d = ptt_pkg::ST_IDLE;
					act = ptt_pkg::A_PLAYOFF;
				end
			end
			default: ;
		endcase
		// floor clear: any move to idle, or a start that leaves it idle, wipes the snapshot and session state
		if (st_d == ptt_pkg::ST_IDLE && ev.op != ptt_pkg::OP_NONE &&
			!(st_q == ptt_pkg::ST_IDLE && ev.op != ptt_pkg::OP_START)) begin
			hsess_d = '0; hnode_d = '0; snap_d = '0; tstart_d = '0; bnode_d = '0;
			bval_d = '0; own_d = '0; cdue_d = '0; rdue_d = '0; seen_d = '0;
			cdone_d = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ptt_pkg::ST_IDLE; held_q <= 1'b0; cdone_q <= 1'b0; own_q <= '0;
			stamp_q <= '0; bval_q <= '0; bnode_q <= '0; hnode_q <= '0; hsess_q <= '0;
			snap_q <= '0; tstart_q <= '0; cdue_q <= '0; rdue_q <= '0; seen_q <= '0;
			vld_q <= 1'b0;
		end else begin
			if (ev_ready) vld_q <= fire;
			if (fire) begin
				st_q <= st_d; held_q <= held_d; cdone_q <= cdone_d; own_q <= own_d;
				stamp_q <= stamp_d; bval_q <= bval_d; bnode_q <= bnode_d;
				hnode_q <= hnode_d; hsess_q <= hsess_d; snap_q <= snap_d;
				tstart_q <= tstart_d; cdue_q <= cdue_d; rdue_q <= rdue_d;
				seen_q <= seen_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			res.actions         <= act;
			res.talk_state      <= st_d;
			res.action_session  <= stamp_d;
			res.current_session <= hsess_d;
			res.speaker         <= hnode_d;
			res.own_arbitration <= snap_d;
		end
	end
endmodule

FILE: src/ptt_floor_arbiter.sv
// channel   dir  width  contents
// s_axis    in   152    event item: opcode, now_ms, session_in, arb_value, source id
// m_axis    out  160    result item: actions, talk_state, sessions, speaker, arbitration
// apb       in   64     four config registers at byte address 8*i
// One item per cycle sustained while m_tready stays high. An item accepted into
// the front register shows its result on m_tdata after passing through a queue entry
// and the back result register. The back end updates all floor state together when it takes an item.
// Reset clears floor state, queue and registers to their defaults.
// Either side may stall; the two-entry queue lets the front keep accepting until it fills.
module ptt_floor_arbiter (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	output logic          s_tready,
	// [2:0] opcode, [34:3] now_ms, [66:35] session_in, [98:67] arb_value,
	// [146:99] source id
	input  logic [151:0]  s_tdata,
	output logic          m_tvalid,
	input  logic          m_tready,
	// [9:0] actions, [12:10] talk_state, [44:13] action_session,
	// [76:45] current_session, [124:77] speaker, [156:125] own_arbitration
	output logic [159:0]  m_tdata,
	input  logic          psel,
	input  logic          penable,
	input  logic          pwrite,
	input  logic [4:0]    paddr,
	input  logic [63:0]   pwdata,
	output logic [63:0]   prdata,
	output logic          pready
);
	logic [47:0] local_id;
	logic [15:0] window_ms, remote_to;
	logic [23:0] max_talk;
	logic fv, fr, qv, qr;
	ptt_pkg::event_t fe, qe;
	ptt_pkg::result_t res;

	ptt_cfg u_cfg (
		.clk, .arst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
		.local_id, .window_ms, .max_talk, .remote_to
	);

	ptt_front u_front (
		.clk, .arst_n, .s_tvalid, .s_tready, .s_tdata, .local_id,
		.ev_valid(fv), .ev_ready(fr), .ev(fe)
	);

	ptt_fifo #(.W(ptt_pkg::EvW)) u_q (
		.clk, .arst_n, .in_valid(fv), .in_ready(fr), .in_data(fe),
		.out_valid(qv), .out_ready(qr), .out_data(qe)
	);

	ptt_back u_back (
		.clk, .arst_n, .ev_valid(qv), .ev_ready(qr), .ev(qe), .local_id,
		.window_ms, .max_talk, .remote_to, .m_tvalid, .m_tready, .res
	);

	assign m_tdata = {3'd0, res.own_arbitration, res.speaker, res.current_session,
		res.action_session, res.talk_state, res.actions};
endmodule
